// ----- sv/stpdp_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the stepper step/direction pulser.
// No dependencies; used by every module of the block.
package stpdp_pkg;

    localparam int DELAY_WIDTH_DEF    = 16;
    localparam int POSITION_WIDTH_DEF = 32;
    localparam int STEPS_WIDTH        = 16;
    localparam int TICKS_WIDTH        = 16;
    localparam int POS_OUT_WIDTH      = 32;
    localparam int CFG_IDX_WIDTH      = 2;
    localparam int CFG_DATA_WIDTH     = 16;

    // command codes carried in the mode field
    typedef enum logic [1:0] {
        MODE_TICK    = 2'd0,
        MODE_MOVE    = 2'd1,
        MODE_ENABLE  = 2'd2,
        MODE_DISABLE = 2'd3
    } t_mode;

    // configuration register indexes
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_CATHODE_MODE      = 2'd0;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_REVERSE_DIRECTION = 2'd1;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_HALF_STEP_TICKS   = 2'd2;

    typedef struct packed {
        logic                          cathode_mode;
        logic                          reverse_direction;
        logic [TICKS_WIDTH-1:0]        half_step_ticks;
    } t_cfg;

    typedef struct packed {
        logic [1:0]                    mode;
        logic signed [STEPS_WIDTH-1:0] steps;
    } t_in_beat;

    typedef struct packed {
        logic                            step_level;
        logic                            dir_level;
        logic                            enable_level;
        logic                            busy_res;
        logic                            accepted;
        logic signed [POS_OUT_WIDTH-1:0] position;
    } t_out_beat;

endpackage

// ----- sv/stepper_step_dir_pulser_top.sv -----
`timescale 1ns / 1ps
// Stepper step/direction pulser, top level. An input beat goes through the input
// register, then the state update into the result register, to the result beat.
// Throughput: one beat per cycle while the result side is not stalled.
// Synchronous active-low reset: config to cathode mode, no reversal, zero
// period; motor disabled, idle, position zero. Depends on stpdp_pkg, stpdp_cfg,
// stpdp_core.
module stepper_step_dir_pulser_top #(
    parameter int DELAY_WIDTH    = stpdp_pkg::DELAY_WIDTH_DEF,
    parameter int POSITION_WIDTH = stpdp_pkg::POSITION_WIDTH_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [stpdp_pkg::CFG_IDX_WIDTH-1:0]  i_cfg_index,
    input  logic [stpdp_pkg::CFG_DATA_WIDTH-1:0] i_cfg_data,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  stpdp_pkg::t_in_beat                  i_in_beat,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output stpdp_pkg::t_out_beat                 o_out_beat
);

    stpdp_pkg::t_cfg      w_cfg;
    stpdp_pkg::t_out_beat w_result;
    stpdp_pkg::t_in_beat  r_in_beat;
    stpdp_pkg::t_out_beat r_out_beat;
    logic                 r_in_valid;
    logic                 r_out_valid;
    logic                 w_out_free;
    logic                 w_fire;

    // result slot free when empty or being drained this cycle
    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_fire     = r_in_valid && w_out_free;
    assign o_in_ready = !r_in_valid || w_out_free;

    stpdp_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    stpdp_core #(
        .DELAY_WIDTH    (DELAY_WIDTH),
        .POSITION_WIDTH (POSITION_WIDTH)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (w_fire),
        .i_beat   (r_in_beat),
        .i_cfg    (w_cfg),
        .o_result (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (w_out_free) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_beat <= i_in_beat;
        end
        if (w_fire) begin
            r_out_beat <= w_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out_beat;

endmodule

// ----- sv/stpdp_cfg.sv -----
`timescale 1ns / 1ps
// Configuration register file: polarity, direction reversal, half-step period.
// Depends on stpdp_pkg.
module stpdp_cfg (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [stpdp_pkg::CFG_IDX_WIDTH-1:0]  i_cfg_index,
    input  logic [stpdp_pkg::CFG_DATA_WIDTH-1:0] i_cfg_data,
    output stpdp_pkg::t_cfg                      o_cfg
);

    stpdp_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.cathode_mode      <= 1'b1;
            r_cfg.reverse_direction <= 1'b0;
            r_cfg.half_step_ticks   <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                stpdp_pkg::CFG_CATHODE_MODE: begin
                    r_cfg.cathode_mode <= i_cfg_data[0];
                end
                stpdp_pkg::CFG_REVERSE_DIRECTION: begin
                    r_cfg.reverse_direction <= i_cfg_data[0];
                end
                stpdp_pkg::CFG_HALF_STEP_TICKS: begin
                    r_cfg.half_step_ticks <= i_cfg_data[stpdp_pkg::TICKS_WIDTH-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ----- sv/stpdp_core.sv -----
`timescale 1ns / 1ps
// Motor state (phase, half-period counter, pulse count, position) and the
// combinational update for one command beat. Depends on stpdp_pkg.
module stpdp_core #(
    parameter int DELAY_WIDTH    = stpdp_pkg::DELAY_WIDTH_DEF,
    parameter int POSITION_WIDTH = stpdp_pkg::POSITION_WIDTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_fire,
    input  stpdp_pkg::t_in_beat  i_beat,
    input  stpdp_pkg::t_cfg      i_cfg,
    output stpdp_pkg::t_out_beat o_result
);

    localparam int SW      = stpdp_pkg::STEPS_WIDTH;
    localparam int POS_EXT = (POSITION_WIDTH > stpdp_pkg::POS_OUT_WIDTH) ?
                             POSITION_WIDTH : stpdp_pkg::POS_OUT_WIDTH;

    typedef enum logic [3:0] {
        PH_IDLE   = 4'b0001,
        PH_LEAD   = 4'b0010,
        PH_ACTIVE = 4'b0100,
        PH_GAP    = 4'b1000
    } t_phase;

    t_phase                      r_phase,   n_phase;
    logic                        r_enabled, n_enabled;
    logic                        r_ccw,     n_ccw;
    logic [DELAY_WIDTH-1:0]      r_delay,   n_delay;
    logic [SW-1:0]               r_left,    n_left;
    logic signed [SW-1:0]        r_amount,  n_amount;
    logic signed [POSITION_WIDTH-1:0] r_pos, n_pos;

    logic                        w_accepted;
    logic [DELAY_WIDTH-1:0]      w_reload;
    logic [SW-1:0]               w_left_dec;
    logic signed [POS_EXT-1:0]   w_pos_ext;

    assign w_reload   = DELAY_WIDTH'(i_cfg.half_step_ticks);
    assign w_left_dec = r_left - SW'(1);

    always_comb begin
        n_phase    = r_phase;
        n_enabled  = r_enabled;
        n_ccw      = r_ccw;
        n_delay    = r_delay;
        n_left     = r_left;
        n_amount   = r_amount;
        n_pos      = r_pos;
        w_accepted = 1'b0;
        case (i_beat.mode)
            stpdp_pkg::MODE_TICK: begin
                if (r_phase != PH_IDLE) begin
                    if (r_delay > DELAY_WIDTH'(1)) begin
                        n_delay = r_delay - DELAY_WIDTH'(1);
                    end else begin
                        case (r_phase)
                            PH_LEAD: begin
                                n_phase = PH_ACTIVE;
                                n_delay = w_reload;
                            end
                            PH_ACTIVE: begin
                                n_phase = PH_GAP;
                                n_delay = w_reload;
                            end
                            PH_GAP: begin
                                n_left = w_left_dec;
                                if (w_left_dec != '0) begin
                                    n_phase = PH_ACTIVE;
                                    n_delay = w_reload;
                                end else begin
                                    // last pulse done: commit the move
                                    n_pos    = r_pos + POSITION_WIDTH'(r_amount);
                                    n_phase  = PH_IDLE;
                                    n_delay  = '0;
                                    n_amount = '0;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
            end
            stpdp_pkg::MODE_MOVE: begin
                if (r_phase == PH_IDLE && r_enabled && i_cfg.half_step_ticks != '0 &&
                    i_beat.steps != '0) begin
                    n_ccw      = i_beat.steps[SW-1];
                    // magnitude; the most negative count wraps to itself
                    n_left     = i_beat.steps[SW-1] ? (SW'(0) - SW'(i_beat.steps))
                                                    : SW'(i_beat.steps);
                    n_amount   = i_beat.steps;
                    n_phase    = PH_LEAD;
                    n_delay    = w_reload;
                    w_accepted = 1'b1;
                end
            end
            stpdp_pkg::MODE_ENABLE: begin
                if (r_phase == PH_IDLE) begin
                    n_enabled  = 1'b1;
                    w_accepted = 1'b1;
                end
            end
            default: begin
                if (r_phase == PH_IDLE) begin
                    n_enabled  = 1'b0;
                    w_accepted = 1'b1;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_enabled <= 1'b0;
            r_ccw     <= 1'b0;
            r_delay   <= '0;
            r_left    <= '0;
            r_amount  <= '0;
            r_pos     <= '0;
        end else if (i_fire) begin
            r_phase   <= n_phase;
            r_enabled <= n_enabled;
            r_ccw     <= n_ccw;
            r_delay   <= n_delay;
            r_left    <= n_left;
            r_amount  <= n_amount;
            r_pos     <= n_pos;
        end
    end

    assign w_pos_ext = POS_EXT'(n_pos);

    always_comb begin
        o_result.step_level   = (n_phase == PH_ACTIVE) ? i_cfg.cathode_mode
                                                       : ~i_cfg.cathode_mode;
        o_result.dir_level    = i_cfg.cathode_mode ^ i_cfg.reverse_direction ^ n_ccw;
        o_result.enable_level = i_cfg.cathode_mode ^ n_enabled;
        o_result.busy_res     = (n_phase != PH_IDLE);
        o_result.accepted     = w_accepted;
        o_result.position     = w_pos_ext[stpdp_pkg::POS_OUT_WIDTH-1:0];
    end

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// Self-checking bench for stepper_step_dir_pulser_top: directed table with a stretch of random
// enable/move/tick sequences in its middle, checked beat by beat against a behavioral predictor.
// Depends on stpdp_pkg and the pulser RTL.
module testbench;
    import stpdp_pkg::*;

    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int RANDOM_BEATS  = 1300;

    typedef enum logic [1:0] {PH_IDLE, PH_LEAD, PH_HIGH, PH_LOW} t_phase;
    typedef enum {ROW_BEAT, ROW_CFG, ROW_DRAIN, ROW_RANDOM} t_row_kind;

    typedef struct {
        t_row_kind                 kind;
        logic [CFG_IDX_WIDTH-1:0]  idx;
        logic [CFG_DATA_WIDTH-1:0] data;
        t_in_beat                  beat;
        bit                        typed;
        t_out_beat                 want;
    } t_row;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_cfg_we = 1'b0;
    logic [CFG_IDX_WIDTH-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_WIDTH-1:0] i_cfg_data = '0;
    logic                      i_in_valid = 1'b0;
    logic                      o_in_ready;
    t_in_beat                  i_in_beat = '0;
    logic                      o_out_valid;
    logic                      i_out_ready = 1'b1;
    t_out_beat                 o_out_beat;

    stepper_step_dir_pulser_top DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_beat   (i_in_beat),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_beat  (o_out_beat)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // predictor copy of registers and motor state
    logic              reg_cathode = 1'b1;
    logic              reg_reverse = 1'b0;
    logic [15:0]       reg_half = '0;
    logic              drv_enabled = 1'b0;
    logic              drv_ccw = 1'b0;
    t_phase            drv_phase = PH_IDLE;
    logic [15:0]       half_left = '0;
    logic [15:0]       pulses_left = '0;
    logic signed [15:0] move_len = '0;
    logic signed [31:0] pos_acc = '0;

    t_out_beat pending_levels[$];
    t_row      plan[$];

    int  errors = 0;
    int  checked = 0;
    int  beats_sent = 0;
    int  useful_beats = 0;
    int  moves_done = 0;
    int  reg_writes = 0;
    int  cycles = 0;
    bit  quiet = 1'b0;
    bit  fast = 1'b0;

    // advance state for one accepted beat and return the levels it must produce
    function automatic t_out_beat pulser_predict(input t_in_beat b);
        t_out_beat r;
        logic      took;
        logic      idle;
        took = 1'b0;
        idle = (drv_phase == PH_IDLE);
        case (t_mode'(b.mode))
            MODE_TICK: begin
                if (drv_phase != PH_IDLE) begin
                    if (half_left > 16'd1) begin
                        half_left = half_left - 16'd1;
                    end else if (drv_phase == PH_LEAD || drv_phase == PH_HIGH) begin
                        drv_phase = (drv_phase == PH_LEAD) ? PH_HIGH : PH_LOW;
                        half_left = reg_half;
                    end else begin
                        pulses_left = pulses_left - 16'd1;
                        if (pulses_left != 0) begin
                            drv_phase = PH_HIGH;
                            half_left = reg_half;
                        end else begin
                            pos_acc   = pos_acc + move_len;
                            drv_phase = PH_IDLE;
                            half_left = '0;
                            move_len  = '0;
                            moves_done++;
                        end
                    end
                end
            end
            MODE_MOVE: begin
                if (idle && drv_enabled && reg_half != 0 && b.steps != 0) begin
                    drv_ccw     = b.steps[15];
                    pulses_left = drv_ccw ? 16'(-b.steps) : 16'(b.steps);
                    move_len    = b.steps;
                    drv_phase   = PH_LEAD;
                    half_left   = reg_half;
                    took        = 1'b1;
                end
            end
            MODE_ENABLE: begin
                if (idle) begin
                    drv_enabled = 1'b1;
                    took        = 1'b1;
                end
            end
            default: begin
                if (idle) begin
                    drv_enabled = 1'b0;
                    took        = 1'b1;
                end
            end
        endcase
        r.step_level   = (drv_phase == PH_HIGH) ? reg_cathode : ~reg_cathode;
        r.dir_level    = reg_cathode ^ reg_reverse ^ drv_ccw;
        r.enable_level = reg_cathode ^ drv_enabled;
        r.busy_res     = (drv_phase != PH_IDLE);
        r.accepted     = took;
        r.position     = pos_acc;
        return r;
    endfunction

    function automatic t_in_beat beat_of(input t_mode m, input int s);
        t_in_beat b;
        b.mode  = m;
        b.steps = s[15:0];
        return b;
    endfunction

    function automatic t_out_beat lv(input bit s, input bit d, input bit e, input bit bz,
                                     input bit a, input int p);
        t_out_beat r;
        r.step_level   = s;
        r.dir_level    = d;
        r.enable_level = e;
        r.busy_res     = bz;
        r.accepted     = a;
        r.position     = p;
        return r;
    endfunction

    function automatic t_row row_beat(input t_mode m, input int s);
        t_row r;
        r = '{ROW_BEAT, '0, '0, beat_of(m, s), 1'b0, '0};
        return r;
    endfunction

    function automatic t_row row_chk(input t_mode m, input int s, input t_out_beat w);
        t_row r;
        r = '{ROW_BEAT, '0, '0, beat_of(m, s), 1'b1, w};
        return r;
    endfunction

    function automatic t_row row_cfg(input logic [CFG_IDX_WIDTH-1:0] idx, input int d);
        t_row r;
        r = '{ROW_CFG, idx, d[15:0], '0, 1'b0, '0};
        return r;
    endfunction

    // mostly short, now and then long
    function automatic int pick_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 20);
    endfunction

    function automatic int pick_period();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8) return 0;
        if (r < 80) return $urandom_range(1, 3);
        return $urandom_range(4, 12);
    endfunction

    function automatic int small_steps();
        int mag;
        mag = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 40) : $urandom_range(1, 6);
        return $urandom_range(0, 1) ? -mag : mag;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("ERROR: result %0d %s: got %0d, expected %0d", checked, what, got, want);
        errors++;
    endtask

    task automatic send_cmd(input t_in_beat b, input bit typed, input t_out_beat want);
        int        gap;
        logic      was_busy;
        t_out_beat pred;
        gap = (quiet || fast) ? 0 : pick_len();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_beat  <= b;
        do @(posedge i_clk); while (!o_in_ready);
        was_busy = (drv_phase != PH_IDLE);
        pred = pulser_predict(b);
        pending_levels.push_back(typed ? want : pred);
        beats_sent++;
        if (was_busy || pred.accepted)
            useful_beats++;
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (pending_levels.size() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_WIDTH-1:0] idx, input int d);
        wait_drained();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= d[15:0];
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        case (idx)
            CFG_CATHODE_MODE:      reg_cathode = d[0];
            CFG_REVERSE_DIRECTION: reg_reverse = d[0];
            CFG_HALF_STEP_TICKS:   reg_half    = d[15:0];
            default: ;
        endcase
        reg_writes++;
    endtask

    task automatic run_episode();
        int    kind;
        int    r;
        int    n;
        t_mode m;
        int    s;
        kind  = $urandom_range(0, 99);
        quiet = ($urandom_range(0, 3) == 0);
        if (kind < 25) begin
            write_reg(CFG_CATHODE_MODE, $urandom_range(0, 1));
            write_reg(CFG_REVERSE_DIRECTION, $urandom_range(0, 1));
            write_reg(CFG_HALF_STEP_TICKS, pick_period());
        end
        if (kind < 80) begin
            if (!drv_enabled || $urandom_range(0, 4) == 0)
                send_cmd(beat_of(MODE_ENABLE, $urandom_range(0, 65535)), 0, '0);
            send_cmd(beat_of(MODE_MOVE, small_steps()), 0, '0);
            while (drv_phase != PH_IDLE) begin
                r = $urandom_range(0, 99);
                if (r < 8)
                    send_cmd(beat_of(t_mode'($urandom_range(1, 3)), $urandom_range(0, 65535)),
                             0, '0);
                else if (r < 10)
                    write_reg(CFG_HALF_STEP_TICKS, pick_period());
                else
                    send_cmd(beat_of(MODE_TICK, $urandom_range(0, 65535)), 0, '0);
            end
            repeat ($urandom_range(0, 3))
                send_cmd(beat_of(MODE_TICK, $urandom_range(0, 65535)), 0, '0);
        end else begin
            // noise and broken sequences; a move that would start stays short
            n = $urandom_range(3, 12);
            repeat (n) begin
                m = t_mode'($urandom_range(0, 3));
                s = $urandom_range(0, 65535);
                if (m == MODE_MOVE && $urandom_range(0, 3) == 0)
                    s = 0;
                if (m == MODE_MOVE && drv_phase == PH_IDLE && drv_enabled && reg_half != 0 &&
                    s != 0)
                    s = small_steps();
                send_cmd(beat_of(m, s), 0, '0);
            end
        end
        if ($urandom_range(0, 9) == 0)
            wait_drained();
    endtask

    // result side: random stalls, with quiet stretches
    int stall_left = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n || quiet || fast) begin
            stall_left = 0;
            i_out_ready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            i_out_ready <= 1'b0;
        end else if ($urandom_range(0, 3) == 0) begin
            stall_left = pick_len();
            i_out_ready <= (stall_left == 0);
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_out_beat want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_levels.size() == 0) begin
                $display("ERROR: result beat with nothing pending");
                errors++;
            end else begin
                want = pending_levels.pop_front();
                if (o_out_beat.step_level !== want.step_level)
                    report_mismatch("step_level", o_out_beat.step_level, want.step_level);
                if (o_out_beat.dir_level !== want.dir_level)
                    report_mismatch("dir_level", o_out_beat.dir_level, want.dir_level);
                if (o_out_beat.enable_level !== want.enable_level)
                    report_mismatch("enable_level", o_out_beat.enable_level, want.enable_level);
                if (o_out_beat.busy_res !== want.busy_res)
                    report_mismatch("busy_res", o_out_beat.busy_res, want.busy_res);
                if (o_out_beat.accepted !== want.accepted)
                    report_mismatch("accepted", o_out_beat.accepted, want.accepted);
                if (o_out_beat.position !== want.position)
                    report_mismatch("position", o_out_beat.position, want.position);
                checked++;
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results still pending", cycles,
                     pending_levels.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        // after reset: cathode polarity, no reversal, zero period, disabled
        plan.push_back(row_chk(MODE_TICK, 0, lv(0, 1, 1, 0, 0, 0)));
        plan.push_back(row_chk(MODE_MOVE, 5, lv(0, 1, 1, 0, 0, 0)));
        plan.push_back(row_chk(MODE_DISABLE, 0, lv(0, 1, 1, 0, 1, 0)));
        plan.push_back(row_chk(MODE_ENABLE, 0, lv(0, 1, 0, 0, 1, 0)));
        plan.push_back(row_chk(MODE_ENABLE, 0, lv(0, 1, 0, 0, 1, 0)));
        plan.push_back(row_chk(MODE_MOVE, 5, lv(0, 1, 0, 0, 0, 0)));
        plan.push_back(row_cfg(CFG_HALF_STEP_TICKS, 1));
        plan.push_back(row_chk(MODE_MOVE, 0, lv(0, 1, 0, 0, 0, 0)));
        // negative move flips direction; commands ignored while it runs
        plan.push_back(row_chk(MODE_MOVE, -2, lv(0, 0, 0, 1, 1, 0)));
        plan.push_back(row_chk(MODE_MOVE, 32767, lv(0, 0, 0, 1, 0, 0)));
        plan.push_back(row_chk(MODE_DISABLE, 0, lv(0, 0, 0, 1, 0, 0)));
        plan.push_back(row_chk(MODE_ENABLE, 0, lv(0, 0, 0, 1, 0, 0)));
        plan.push_back(row_chk(MODE_TICK, 0, lv(1, 0, 0, 1, 0, 0)));
        plan.push_back('{ROW_DRAIN, '0, '0, '0, 1'b0, '0});
        plan.push_back(row_cfg(CFG_CATHODE_MODE, 0));
        plan.push_back(row_beat(MODE_TICK, 16'hffff));
        plan.push_back(row_cfg(CFG_REVERSE_DIRECTION, 1));
        plan.push_back(row_beat(MODE_MOVE, 3));
        plan.push_back('{ROW_DRAIN, '0, '0, '0, 1'b0, '0});
        plan.push_back(row_cfg(CFG_CATHODE_MODE, 1));
        // period cut to zero mid-move: later half periods last one tick
        plan.push_back(row_cfg(CFG_HALF_STEP_TICKS, 3));
        plan.push_back(row_beat(MODE_MOVE, -2));
        plan.push_back(row_beat(MODE_TICK, 0));
        plan.push_back(row_cfg(CFG_HALF_STEP_TICKS, 0));
        plan.push_back('{ROW_DRAIN, '0, '0, '0, 1'b0, '0});
        plan.push_back(row_cfg(CFG_HALF_STEP_TICKS, 2));
        plan.push_back(row_beat(MODE_DISABLE, 0));
        plan.push_back(row_beat(MODE_MOVE, 7));
        plan.push_back(row_cfg(CFG_REVERSE_DIRECTION, 0));
        plan.push_back('{ROW_RANDOM, '0, '0, '0, 1'b0, '0});
        // most negative count at the longest period; still running when the run ends
        plan.push_back('{ROW_DRAIN, '0, '0, '0, 1'b0, '0});
        plan.push_back(row_cfg(CFG_CATHODE_MODE, 1));
        plan.push_back(row_cfg(CFG_REVERSE_DIRECTION, 0));
        plan.push_back(row_cfg(CFG_HALF_STEP_TICKS, 65535));
        plan.push_back(row_beat(MODE_ENABLE, 0));
        plan.push_back(row_beat(MODE_MOVE, -32768));
        plan.push_back(row_beat(MODE_MOVE, 32767));
        plan.push_back(row_beat(MODE_DISABLE, 0));
        plan.push_back(row_beat(MODE_ENABLE, 0));
        plan.push_back(row_beat(MODE_TICK, 0));
        plan.push_back(row_beat(MODE_TICK, 0));

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (plan[k]) begin
            case (plan[k].kind)
                ROW_CFG: write_reg(plan[k].idx, plan[k].data);
                ROW_DRAIN: begin
                    fast = 1'b1;
                    while (drv_phase != PH_IDLE)
                        send_cmd(beat_of(MODE_TICK, $urandom_range(0, 65535)), 0, '0);
                    fast = 1'b0;
                end
                ROW_RANDOM: begin
                    while (beats_sent < RANDOM_BEATS)
                        run_episode();
                    quiet = 1'b0;
                end
                default: send_cmd(plan[k].beat, plan[k].typed, plan[k].want);
            endcase
        end

        wait_drained();
        repeat (8) @(posedge i_clk);
        if (pending_levels.size() != 0) begin
            $display("ERROR: %0d results never arrived", pending_levels.size());
            errors++;
        end

        $display("Covered %0d beats (%0d with effect), %0d moves finished, %0d register writes",
                 beats_sent, useful_beats, moves_done, reg_writes);
        $display("Checked %0d results, %0d mismatches", checked, errors);
        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
